// File: rtl/core/cabp_pkg.sv
// Shared types and constants for the clipped alpha blit pixel pipeline.
package cabp_pkg;

    localparam int CfgW   = 13;
    localparam int RowW   = 12;
    localparam int PixW   = 32;
    localparam int IdxW   = 24;
    localparam int ChW    = 8;
    localparam int NumCh  = 3;
    localparam int CfgAw  = 3;
    localparam int ModeW  = 2;
    localparam int MaxDimDefault = 4096;

    localparam logic [ModeW-1:0] MODE_COPY   = 2'd0;
    localparam logic [ModeW-1:0] MODE_BLEND  = 2'd1;
    localparam logic [ModeW-1:0] MODE_ROTATE = 2'd2;
    localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

    localparam logic [CfgAw-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CfgAw-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CfgAw-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CfgAw-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CfgAw-1:0] REG_SRC_X      = 3'd4;
    localparam logic [CfgAw-1:0] REG_SRC_Y      = 3'd5;
    localparam logic [CfgAw-1:0] REG_DST_X      = 3'd6;
    localparam logic [CfgAw-1:0] REG_DST_Y      = 3'd7;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } cabp_adv_t;

    typedef struct packed {
        logic [CfgW-1:0]        src_w;
        logic [CfgW-1:0]        src_h;
        logic [CfgW-1:0]        dst_w;
        logic [CfgW-1:0]        dst_h;
        logic signed [CfgW-1:0] src_x;
        logic signed [CfgW-1:0] src_y;
        logic signed [CfgW-1:0] dst_x;
        logic signed [CfgW-1:0] dst_y;
    } cabp_geom_t;

endpackage

// File: rtl/core/clipped_alpha_blit_pixel.sv
// Top level of the clipped alpha blit pixel core: registers, pipeline control, output stage.
//
//  Channel   Direction  Payload
//  s_*       in         tuser: mode; tdata: row, col, src_pixel, dst_pixel
//  m_*       out        tuser: write_enable; tdata: src_index, dst_index, out_pixel
//  cfg_*     in         register index and write data, no read-back
//
// One beat enters per cycle while s_tready is high; each accepted beat enters the first of
// three compute stages at the accepting edge, then moves through the other two and into the
// output stage. The index multipliers and the blend multipliers each sit in a stage of
// their own.
// Reset is synchronous and clears the valid bits and the geometry registers.
// A stall at the output fills empty stages first; s_tready drops only when every stage
// holds a beat and the output beat is not taken.
module clipped_alpha_blit_pixel import cabp_pkg::*; #(
    parameter int MAX_DIM = MaxDimDefault
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ModeW-1:0]        s_tuser,  // mode
    input  logic [4*ChW+4*ChW+2*RowW-1:0] s_tdata,
                                              // row, col, src_pixel, dst_pixel
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic                    m_tuser,  // write_enable
    output logic [2*IdxW+PixW-1:0]  m_tdata,  // src_index, dst_index, out_pixel
    input  logic                    cfg_wr_en,
    input  logic [CfgAw-1:0]        cfg_addr,
    input  logic [CfgW-1:0]         cfg_wdata
);

    cabp_geom_t            geom_reg;
    logic [CfgW-1:0]       dim_clamped;
    cabp_adv_t             adv;
    logic                  out_rdy;
    logic                  v1_reg, v2_reg, v3_reg;
    logic [ModeW-1:0]      mode1_reg, mode2_reg, mode3_reg;
    logic [PixW-1:0]       spix1_reg, spix2_reg, spix3_reg;
    logic [RowW-1:0]       in_row, in_col;
    logic [PixW-1:0]       in_src, in_dst;
    logic                  addr_ok;
    logic [IdxW-1:0]       src_index, dst_index;
    logic [NumCh*ChW-1:0]  rgb;
    logic                  we_next;
    logic [PixW-1:0]       pix_sel;
    logic                  m_valid_reg;
    logic                  m_we_reg;
    logic [2*IdxW+PixW-1:0] m_data_reg;

    assign in_row = s_tdata[RowW-1:0];
    assign in_col = s_tdata[2*RowW-1:RowW];
    assign in_src = s_tdata[2*RowW+PixW-1:2*RowW];
    assign in_dst = s_tdata[2*RowW+2*PixW-1:2*RowW+PixW];

    assign dim_clamped = (32'(cfg_wdata) > 32'(MAX_DIM)) ? CfgW'(MAX_DIM) : cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SRC_WIDTH:  geom_reg.src_w <= dim_clamped;
                REG_SRC_HEIGHT: geom_reg.src_h <= dim_clamped;
                REG_DST_WIDTH:  geom_reg.dst_w <= dim_clamped;
                REG_DST_HEIGHT: geom_reg.dst_h <= dim_clamped;
                REG_SRC_X:      geom_reg.src_x <= cfg_wdata;
                REG_SRC_Y:      geom_reg.src_y <= cfg_wdata;
                REG_DST_X:      geom_reg.dst_x <= cfg_wdata;
                REG_DST_Y:      geom_reg.dst_y <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_rdy  = !m_valid_reg || m_tready;
    assign adv.s3   = !v3_reg || out_rdy;
    assign adv.s2   = !v2_reg || adv.s3;
    assign adv.s1   = !v1_reg || adv.s2;
    assign s_tready = adv.s1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv.s1) v1_reg <= s_tvalid;
            if (adv.s2) v2_reg <= v1_reg;
            if (adv.s3) v3_reg <= v2_reg;
            if (out_rdy) m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            mode1_reg <= s_tuser;
            spix1_reg <= in_src;
        end
        if (adv.s2) begin
            mode2_reg <= mode1_reg;
            spix2_reg <= spix1_reg;
        end
        if (adv.s3) begin
            mode3_reg <= mode2_reg;
            spix3_reg <= spix2_reg;
        end
    end

    cabp_addr u_addr (
        .aclk      (aclk),
        .adv       (adv),
        .geom      (geom_reg),
        .row       (in_row),
        .col       (in_col),
        .ok        (addr_ok),
        .src_index (src_index),
        .dst_index (dst_index)
    );

    cabp_blend u_blend (
        .aclk      (aclk),
        .adv       (adv),
        .src_pixel (in_src),
        .dst_pixel (in_dst),
        .rgb       (rgb)
    );

    // Blended pixels carry full alpha; the rotated form moves blue to the top byte.
    always_comb begin
        unique case (mode3_reg)
            MODE_COPY:   pix_sel = spix3_reg;
            MODE_BLEND:  pix_sel = {8'hFF, rgb};
            MODE_ROTATE: pix_sel = {rgb[ChW-1:0], 8'hFF, rgb[NumCh*ChW-1:ChW]};
            default:     pix_sel = '0;
        endcase
        we_next = addr_ok && (mode3_reg != MODE_UNUSED);
    end

    always_ff @(posedge aclk) begin
        if (out_rdy) begin
            m_we_reg   <= we_next;
            m_data_reg <= we_next ? {pix_sel, dst_index, src_index} : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_we_reg;
    assign m_tdata  = m_data_reg;

    a_zero_when_clipped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_we_reg |-> m_data_reg == '0)
        else $error("clipped beat carries nonzero payload");

    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !adv.s2 |=> v1_reg)
        else $error("stalled beat lost from stage 1");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted beat did not enter stage 1");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_tready)
        else $error("input stalled with an empty first stage");

endmodule

// File: rtl/core/cabp_addr.sv
// Three-stage clip check and linear index computation for both surfaces.
module cabp_addr import cabp_pkg::*; (
    input  logic            aclk,
    input  cabp_adv_t       adv,
    input  cabp_geom_t      geom,
    input  logic [RowW-1:0] row,
    input  logic [RowW-1:0] col,
    output logic            ok,
    output logic [IdxW-1:0] src_index,
    output logic [IdxW-1:0] dst_index
);

    localparam int CoordW = CfgW + 1;

    logic signed [CoordW-1:0] sy, sx, dy, dx;
    logic                     ok_s1;
    logic [CfgW-1:0]          sy_reg, sx_reg, dy_reg, dx_reg;
    logic                     ok1_reg, ok2_reg, ok3_reg;
    logic [2*CfgW-1:0]        sprod, dprod;
    logic [IdxW-1:0]          sprod_reg, dprod_reg;
    logic [CfgW-1:0]          sx2_reg, dx2_reg;
    logic [IdxW-1:0]          sidx_reg, didx_reg;

    // Stage 1: place the offset on both surfaces and clip.
    always_comb begin
        sy = CoordW'(geom.src_y) + $signed({2'b00, row});
        sx = CoordW'(geom.src_x) + $signed({2'b00, col});
        dy = CoordW'(geom.dst_y) + $signed({2'b00, row});
        dx = CoordW'(geom.dst_x) + $signed({2'b00, col});
        ok_s1 = !sy[CoordW-1] && (sy[CfgW-1:0] < geom.src_h)
             && !sx[CoordW-1] && (sx[CfgW-1:0] < geom.src_w)
             && !dy[CoordW-1] && (dy[CfgW-1:0] < geom.dst_h)
             && !dx[CoordW-1] && (dx[CfgW-1:0] < geom.dst_w);
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            ok1_reg <= ok_s1;
            sy_reg  <= sy[CfgW-1:0];
            sx_reg  <= sx[CfgW-1:0];
            dy_reg  <= dy[CfgW-1:0];
            dx_reg  <= dx[CfgW-1:0];
        end
    end

    // Stage 2: row times surface width.
    assign sprod = sy_reg * geom.src_w;
    assign dprod = dy_reg * geom.dst_w;

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            ok2_reg   <= ok1_reg;
            sprod_reg <= sprod[IdxW-1:0];
            dprod_reg <= dprod[IdxW-1:0];
            sx2_reg   <= sx_reg;
            dx2_reg   <= dx_reg;
        end
    end

    // Stage 3: add the column, wrapping at the index width.
    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            ok3_reg  <= ok2_reg;
            sidx_reg <= sprod_reg + IdxW'(sx2_reg);
            didx_reg <= dprod_reg + IdxW'(dx2_reg);
        end
    end

    assign ok        = ok3_reg;
    assign src_index = sidx_reg;
    assign dst_index = didx_reg;

endmodule

// File: rtl/core/cabp_blend.sv
// Three-stage per-channel alpha blend with exact truncating division by 255.
module cabp_blend import cabp_pkg::*; (
    input  logic                aclk,
    input  cabp_adv_t           adv,
    input  logic [PixW-1:0]     src_pixel,
    input  logic [PixW-1:0]     dst_pixel,
    output logic [NumCh*ChW-1:0] rgb
);

    localparam int ProdW = 2 * ChW;
    localparam logic [ChW-1:0] Full = '1;

    logic [ChW-1:0]   alpha, alpha_inv;
    logic [ProdW-1:0] ps_reg [NumCh];
    logic [ProdW-1:0] pd_reg [NumCh];
    logic [ProdW-1:0] sum_reg [NumCh];
    logic [ProdW-1:0] quot [NumCh];
    logic [ChW-1:0]   ch_reg [NumCh];

    assign alpha     = src_pixel[PixW-1 -: ChW];
    assign alpha_inv = Full - alpha;

    always_ff @(posedge aclk) begin
        for (int c = 0; c < NumCh; c++) begin
            if (adv.s1) begin
                ps_reg[c] <= alpha * src_pixel[c*ChW +: ChW];
                pd_reg[c] <= alpha_inv * dst_pixel[c*ChW +: ChW];
            end
            if (adv.s2) begin
                sum_reg[c] <= ps_reg[c] + pd_reg[c];
            end
            if (adv.s3) begin
                ch_reg[c] <= quot[c][ProdW-1 -: ChW];
            end
        end
    end

    // x / 255 equals (x + 1 + (x >> 8)) >> 8 for every sum that can occur here.
    always_comb begin
        for (int c = 0; c < NumCh; c++) begin
            quot[c] = sum_reg[c] + ProdW'(1) + ProdW'(sum_reg[c][ProdW-1:ChW]);
        end
    end

    always_comb begin
        for (int c = 0; c < NumCh; c++) begin
            rgb[c*ChW +: ChW] = ch_reg[c];
        end
    end

endmodule

// File: tb/clipped_alpha_blit_pixel_tb.sv
// Self-checking testbench for the clipped alpha blit pixel core: directed rows, then random beats.
module clipped_alpha_blit_pixel_tb;
    import cabp_pkg::*;

    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] si;
        logic [IdxW-1:0] di;
        logic [PixW-1:0] px;
    } blit_result_t;

    typedef struct {
        int                geom;
        logic [ModeW-1:0]  mode;
        int                row;
        int                col;
        logic [PixW-1:0]   sp;
        logic [PixW-1:0]   dp;
        bit                by_hand;
        blit_result_t      want;
    } directed_row_t;

    localparam int NumDirected = 24;
    localparam int NumPhases   = 9;
    localparam int BeatsPerPhase = 160;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ModeW-1:0] s_tuser = '0;
    logic [4*ChW+4*ChW+2*RowW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic m_tuser;
    logic [2*IdxW+PixW-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CfgAw-1:0] cfg_addr = '0;
    logic [CfgW-1:0] cfg_wdata = '0;

    // Shadow copy of the geometry registers.
    int src_w_m = 0, src_h_m = 0, dst_w_m = 0, dst_h_m = 0;
    int src_x_m = 0, src_y_m = 0, dst_x_m = 0, dst_y_m = 0;

    blit_result_t pending_pixels[$];
    int mismatches = 0;
    int send_idle_pct = 33;
    int recv_idle_pct = 72;
    logic hold_off_req = 1'b0;
    logic hold_off_done = 1'b0;
    int hold_cnt = 0;

    cabp_geom_t geoms[5];
    directed_row_t directed_rows[NumDirected];

    clipped_alpha_blit_pixel dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic int dim_of(logic [CfgW-1:0] value);
        return (value > MaxDimDefault) ? MaxDimDefault : int'(value);
    endfunction

    function automatic blit_result_t blit_pixel(logic [ModeW-1:0] mode, int row, int col,
                                                logic [PixW-1:0] sp, logic [PixW-1:0] dp);
        blit_result_t res;
        int sy, sx, dy, dx, a, s, d, c;
        logic [PixW-1:0] px;
        res = '0;
        sy = src_y_m + row;
        sx = src_x_m + col;
        dy = dst_y_m + row;
        dx = dst_x_m + col;
        if (mode == MODE_UNUSED || sy < 0 || sy >= src_h_m || sx < 0 || sx >= src_w_m ||
            dy < 0 || dy >= dst_h_m || dx < 0 || dx >= dst_w_m) begin
            return res;
        end
        if (mode == MODE_COPY) begin
            px = sp;
        end else begin
            a = sp[31:24];
            px[31:24] = 8'hFF;
            for (c = 0; c < NumCh; c++) begin
                s = sp[c*ChW +: ChW];
                d = dp[c*ChW +: ChW];
                px[c*ChW +: ChW] = 8'((a * s + (255 - a) * d) / 255);
            end
            if (mode == MODE_ROTATE) begin
                px = {px[7:0], px[31:8]};
            end
        end
        res.we = 1'b1;
        res.si = IdxW'(sy * src_w_m + sx);
        res.di = IdxW'(dy * dst_w_m + dx);
        res.px = px;
        return res;
    endfunction

    // Picks an offset that lands inside both surfaces most of the time.
    function automatic int pick_offset(int pos_a, int size_a, int pos_b, int size_b);
        int lo, hi;
        lo = 0;
        if (-pos_a > lo) lo = -pos_a;
        if (-pos_b > lo) lo = -pos_b;
        hi = size_a - pos_a;
        if (size_b - pos_b < hi) hi = size_b - pos_b;
        hi = hi - 1;
        if (hi > 4095) hi = 4095;
        if (lo <= hi && $urandom_range(0, 3) != 0) return $urandom_range(lo, hi);
        return $urandom_range(0, 4095);
    endfunction

    function automatic logic [CfgW-1:0] random_dim();
        if ($urandom_range(0, 3) == 0) return CfgW'($urandom_range(0, 8191));
        return CfgW'($urandom_range(1, 48));
    endfunction

    function automatic logic [CfgW-1:0] random_pos();
        if ($urandom_range(0, 4) == 0) return CfgW'($urandom);
        return CfgW'(int'($urandom_range(0, 40)) - 20);
    endfunction

    task automatic write_reg(logic [CfgAw-1:0] addr, logic [CfgW-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        case (addr)
            REG_SRC_WIDTH:  src_w_m = dim_of(value);
            REG_SRC_HEIGHT: src_h_m = dim_of(value);
            REG_DST_WIDTH:  dst_w_m = dim_of(value);
            REG_DST_HEIGHT: dst_h_m = dim_of(value);
            REG_SRC_X:      src_x_m = $signed(value);
            REG_SRC_Y:      src_y_m = $signed(value);
            REG_DST_X:      dst_x_m = $signed(value);
            REG_DST_Y:      dst_y_m = $signed(value);
            default: ;
        endcase
    endtask

    task automatic write_geometry(cabp_geom_t g);
        write_reg(REG_SRC_WIDTH, g.src_w);
        write_reg(REG_SRC_HEIGHT, g.src_h);
        write_reg(REG_DST_WIDTH, g.dst_w);
        write_reg(REG_DST_HEIGHT, g.dst_h);
        write_reg(REG_SRC_X, g.src_x);
        write_reg(REG_SRC_Y, g.src_y);
        write_reg(REG_DST_X, g.dst_x);
        write_reg(REG_DST_Y, g.dst_y);
        cfg_wr_en <= 1'b0;
    endtask

    // Drops valid and waits until every expected pixel has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic send_beat(logic [ModeW-1:0] mode, int row, int col,
                             logic [PixW-1:0] sp, logic [PixW-1:0] dp, blit_result_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {dp, sp, RowW'(col), RowW'(row)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_pixels.push_back(want);
    endtask

    always @(posedge aclk) begin
        if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_cnt = 80;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        blit_result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[23:0], m_tdata[47:24], m_tdata[79:48]};
            if (pending_pixels.size() == 0) begin
                $display("%0t unexpected beat: we=%0d si=%h di=%h px=%h",
                         $time, got.we, got.si, got.di, got.px);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (got.we !== want.we) begin
                    $display("%0t write_enable: expected %0d got %0d", $time, want.we, got.we);
                    mismatches++;
                end
                if (got.si !== want.si) begin
                    $display("%0t src_index: expected %h got %h", $time, want.si, got.si);
                    mismatches++;
                end
                if (got.di !== want.di) begin
                    $display("%0t dst_index: expected %h got %h", $time, want.di, got.di);
                    mismatches++;
                end
                if (got.px !== want.px) begin
                    $display("%0t out_pixel: expected %h got %h", $time, want.px, got.px);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("clipped_alpha_blit_pixel: mismatch");
        $finish;
    end

    initial begin
        int cur_geom, i, p, n, row, col;
        logic [ModeW-1:0] mode;
        logic [PixW-1:0] sp, dp;
        blit_result_t want;

        geoms = '{
            '{13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0},
            '{13'd16, 13'd16, 13'd16, 13'd16, 13'd0, 13'd0, 13'd0, 13'd0},
            '{13'd8191, 13'd4096, 13'd4096, 13'd4097, 13'd0, 13'd0, 13'd0, 13'd0},
            '{13'd4096, 13'd4096, 13'd4096, 13'd4096,
              13'h1000, 13'h0FFF, 13'h0FFF, 13'h1000},
            '{13'd20, 13'd10, 13'd30, 13'd12, 13'h1FFB, 13'h1FFD, 13'd7, 13'd2}
        };
        directed_rows = '{
            '{0, MODE_COPY, 0, 0, 32'hDEADBEEF, 32'h01234567, 1'b1, '0},
            '{0, MODE_BLEND, 4095, 4095, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '0},
            '{1, MODE_COPY, 0, 0, 32'hDEADBEEF, 32'h01234567, 1'b1,
              '{1'b1, 24'h0, 24'h0, 32'hDEADBEEF}},
            '{1, MODE_COPY, 15, 15, 32'h00000000, 32'hFFFFFFFF, 1'b1,
              '{1'b1, 24'hFF, 24'hFF, 32'h00000000}},
            '{1, MODE_COPY, 16, 0, 32'h12345678, 32'h0, 1'b1, '0},
            '{1, MODE_COPY, 0, 16, 32'h12345678, 32'h0, 1'b1, '0},
            '{1, MODE_UNUSED, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '0},
            '{1, MODE_UNUSED, 4095, 4095, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '0},
            '{1, MODE_BLEND, 1, 2, 32'hFF123456, 32'h00ABCDEF, 1'b1,
              '{1'b1, 24'h12, 24'h12, 32'hFF123456}},
            '{1, MODE_BLEND, 2, 1, 32'h00123456, 32'h00ABCDEF, 1'b1,
              '{1'b1, 24'h21, 24'h21, 32'hFFABCDEF}},
            '{1, MODE_ROTATE, 3, 3, 32'hFF123456, 32'h0, 1'b1,
              '{1'b1, 24'h33, 24'h33, 32'h56FF1234}},
            '{1, MODE_ROTATE, 4, 4, 32'h00123456, 32'h80ABCDEF, 1'b1,
              '{1'b1, 24'h44, 24'h44, 32'hEFFFABCD}},
            '{1, MODE_BLEND, 5, 5, 32'h80FF0000, 32'h0000FF00, 1'b0, '0},
            '{1, MODE_ROTATE, 7, 9, 32'h7F808080, 32'h00FF00FF, 1'b0, '0},
            '{2, MODE_COPY, 4095, 4095, 32'hFFFFFFFF, 32'h0, 1'b1,
              '{1'b1, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF}},
            '{2, MODE_COPY, 0, 4095, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b1,
              '{1'b1, 24'hFFF, 24'hFFF, 32'hA5A5A5A5}},
            '{2, MODE_BLEND, 4095, 0, 32'hFF000000, 32'hFFFFFFFF, 1'b1,
              '{1'b1, 24'hFFF000, 24'hFFF000, 32'hFF000000}},
            '{3, MODE_COPY, 0, 0, 32'h11111111, 32'h22222222, 1'b1, '0},
            '{3, MODE_COPY, 4095, 4095, 32'h11111111, 32'h22222222, 1'b1, '0},
            '{3, MODE_BLEND, 0, 4095, 32'h11111111, 32'h22222222, 1'b1, '0},
            '{4, MODE_COPY, 3, 5, 32'h0F1E2D3C, 32'hC3D2E1F0, 1'b0, '0},
            '{4, MODE_BLEND, 2, 4, 32'h40102030, 32'h80FFEEDD, 1'b0, '0},
            '{4, MODE_ROTATE, 9, 12, 32'hC0AA5500, 32'h3355AAFF, 1'b0, '0},
            '{4, MODE_COPY, 10, 0, 32'h76543210, 32'h89ABCDEF, 1'b0, '0}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cur_geom = 0;
        for (i = 0; i < NumDirected; i++) begin
            if (directed_rows[i].geom != cur_geom) begin
                drain();
                cur_geom = directed_rows[i].geom;
                write_geometry(geoms[cur_geom]);
            end
            if (directed_rows[i].by_hand) begin
                want = directed_rows[i].want;
            end else begin
                want = blit_pixel(directed_rows[i].mode, directed_rows[i].row,
                                  directed_rows[i].col, directed_rows[i].sp,
                                  directed_rows[i].dp);
            end
            send_beat(directed_rows[i].mode, directed_rows[i].row, directed_rows[i].col,
                      directed_rows[i].sp, directed_rows[i].dp, want);
        end

        for (p = 0; p < NumPhases; p++) begin
            drain();
            if (p == 3) begin
                send_idle_pct = 72;
                recv_idle_pct <= 33;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
                hold_off_req <= 1'b1;
            end
            write_geometry('{random_dim(), random_dim(), random_dim(), random_dim(),
                             random_pos(), random_pos(), random_pos(), random_pos()});
            for (n = 0; n < BeatsPerPhase; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: mode = MODE_COPY;
                    3, 4, 5: mode = MODE_BLEND;
                    6, 7, 8: mode = MODE_ROTATE;
                    default: mode = MODE_UNUSED;
                endcase
                row = pick_offset(src_y_m, src_h_m, dst_y_m, dst_h_m);
                col = pick_offset(src_x_m, src_w_m, dst_x_m, dst_w_m);
                sp = $urandom;
                dp = $urandom;
                if ($urandom_range(0, 7) == 0) sp[31:24] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                send_beat(mode, row, col, sp, dp, blit_pixel(mode, row, col, sp, dp));
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("clipped_alpha_blit_pixel: match");
        end else begin
            $display("clipped_alpha_blit_pixel: mismatch");
        end
        $finish;
    end

endmodule

// File: clipped_alpha_blit_pixel.f
rtl/core/cabp_pkg.sv
rtl/core/cabp_addr.sv
rtl/core/cabp_blend.sv
rtl/core/clipped_alpha_blit_pixel.sv
tb/clipped_alpha_blit_pixel_tb.sv
